### src/splq_pkg.sv
// Package for the sorted priority list queue: widths, op and status codes,
// the packed entry type. No dependencies.
package splq_pkg;
    localparam int Depth    = 64;
    localparam int TagBits  = 16;
    localparam int PrioBits = 16;
    localparam int AddrBits = $clog2(Depth);
    localparam int CntBits  = $clog2(Depth + 1);

    typedef logic [2:0] t_op;
    localparam t_op OP_INSERT    = 3'd0;
    localparam t_op OP_PUSH_HEAD = 3'd1;
    localparam t_op OP_PUSH_TAIL = 3'd2;
    localparam t_op OP_POP_HEAD  = 3'd3;
    localparam t_op OP_POP_TAIL  = 3'd4;
    localparam t_op OP_REMOVE    = 3'd5;

    typedef logic [1:0] t_status;
    localparam t_status ST_DONE      = 2'd0;
    localparam t_status ST_EMPTY     = 2'd1;
    localparam t_status ST_FULL      = 2'd2;
    localparam t_status ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [TagBits-1:0]         tag;
        logic signed [PrioBits-1:0] prio;
    } t_entry;
endpackage

### src/splq_if.sv
// Valid/ready channel interfaces for the queue's request, result and
// configuration ports. Depends on splq_pkg.
interface splq_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [2:0]                            op;
    logic [splq_pkg::TagBits-1:0]          tag;
    logic signed [splq_pkg::PrioBits-1:0]  priority_req;
    modport source (output valid, op, tag, priority_req, input ready);
    modport sink   (input valid, op, tag, priority_req, output ready);
endinterface

interface splq_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic [splq_pkg::TagBits-1:0]          out_tag;
    logic signed [splq_pkg::PrioBits-1:0]  out_priority;
    logic [1:0]                            status;
    logic [splq_pkg::CntBits-1:0]          entry_count;
    modport source (output valid, out_tag, out_priority, status, entry_count, input ready);
    modport sink   (input valid, out_tag, out_priority, status, entry_count, output ready);
endinterface

interface splq_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### src/sorted_priority_list_queue_top.sv
// Sorted priority list queue, top level. Entries live in one synchronous
// memory; a sequencer scans and shifts them. Depends on splq_pkg, splq_if.
//
//  channel   dir   payload                                   handshake
//  req       in    op, tag, priority_req                     valid/ready
//  rsp       out   out_tag, out_priority, status, entry_count valid/ready
//  cfg       in    ascending_order (data)                    valid/ready
//
// Full, empty and unused ops go straight to the result. Insert: a scan then a
// shift. Push head, pop head and remove shift too; each shift step is one
// memory read then one write. Reset clears the count and sets the order bit
// to ascending; memory contents need no clear. A request is taken only when
// the result register is empty.
module sorted_priority_list_queue_top (
    input  logic i_clk,
    input  logic i_rst_n,
    splq_req_if.sink   req,
    splq_rsp_if.source rsp,
    splq_cfg_if.sink   cfg
);
    localparam int AW = splq_pkg::AddrBits;
    localparam int CW = splq_pkg::CntBits;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_SRD   = 6'b000100,
        S_SWR   = 6'b001000,
        S_TAKE  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    splq_pkg::t_entry r_mem [splq_pkg::Depth];
    splq_pkg::t_entry r_rd;
    logic             r_wr_en;
    logic [AW-1:0]    r_wr_addr;
    splq_pkg::t_entry r_wr_data;
    logic [AW-1:0]    rd_addr;

    t_state                 r_state;
    logic                   r_asc;
    logic [CW-1:0]          r_count;
    logic [2:0]             r_op;
    splq_pkg::t_entry       r_new;
    logic [CW-1:0]          r_idx;   // scan/shift cursor
    logic [CW-1:0]          r_pos;   // target position
    logic                   r_rvalid; // r_rd holds entry r_idx from scan
    logic                   r_insert; // shift direction: up for insert
    logic                   r_ovalid;
    splq_pkg::t_entry       r_oent;
    logic [1:0]             r_ostat;
    logic [CW-1:0]          r_ocnt;

    // Memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (r_wr_en) r_mem[r_wr_addr] <= r_wr_data;
        r_rd <= r_mem[rd_addr];
    end

    assign cfg.ready = 1'b1;
    assign req.ready = (r_state == S_IDLE) && !r_ovalid;
    assign rsp.valid = r_ovalid;
    assign rsp.out_tag = r_oent.tag;
    assign rsp.out_priority = r_oent.prio;
    assign rsp.status = r_ostat;
    assign rsp.entry_count = r_ocnt;

    logic precedes, match;
    assign precedes = r_asc ? (r_new.prio < r_rd.prio) : (r_new.prio >= r_rd.prio);
    assign match = r_rd.tag == r_new.tag;

    // Read address: scan reads r_idx; shift reads the neighbor to move
    always_comb begin
        rd_addr = r_idx[AW-1:0];
        if (r_state == S_SRD || r_state == S_SWR) begin
            if (r_insert) rd_addr = AW'(r_idx - CW'(1));
            else          rd_addr = AW'(r_idx + CW'(1));
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        r_wr_en <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_asc <= 1'b1; r_count <= '0; r_ovalid <= 1'b0;
            r_rvalid <= 1'b0;
        end else begin
            if (cfg.valid) r_asc <= cfg.data;
            if (rsp.valid && rsp.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (req.valid && req.ready) begin
                    r_op <= req.op;
                    r_new <= '{tag: req.tag, prio: req.priority_req};
                    r_oent <= '0; r_ostat <= splq_pkg::ST_DONE; r_ocnt <= r_count;
                    r_idx <= '0; r_rvalid <= 1'b0;
                    case (req.op)
                        splq_pkg::OP_INSERT, splq_pkg::OP_PUSH_HEAD,
                        splq_pkg::OP_PUSH_TAIL: begin
                            if (r_count == CW'(splq_pkg::Depth)) begin
                                r_ostat <= splq_pkg::ST_FULL; r_state <= S_OUT;
                            end else if (req.op == splq_pkg::OP_INSERT) begin
                                r_state <= S_SCAN;
                            end else begin
                                r_insert <= 1'b1;
                                r_pos <= (req.op == splq_pkg::OP_PUSH_HEAD) ? '0 : r_count;
                                r_idx <= r_count; r_state <= S_SRD;
                            end
                        end
                        splq_pkg::OP_POP_HEAD, splq_pkg::OP_POP_TAIL: begin
                            if (r_count == '0) begin
                                r_ostat <= splq_pkg::ST_EMPTY; r_state <= S_OUT;
                            end else begin
                                r_idx <= (req.op == splq_pkg::OP_POP_HEAD) ? '0
                                         : r_count - CW'(1);
                                r_state <= S_TAKE;
                            end
                        end
                        splq_pkg::OP_REMOVE: r_state <= S_SCAN;
                        default: r_state <= S_OUT;
                    endcase
                end
                // Each entry: issue read, then compare
                S_SCAN: begin
                    if (!r_rvalid) begin
                        if (r_idx == r_count) begin
                            if (r_op == splq_pkg::OP_INSERT) begin
                                r_insert <= 1'b1; r_pos <= r_count; r_state <= S_SRD;
                            end else begin
                                r_ostat <= splq_pkg::ST_NOT_FOUND; r_state <= S_OUT;
                            end
                        end else r_rvalid <= 1'b1;
                    end else begin
                        r_rvalid <= 1'b0;
                        if (r_op == splq_pkg::OP_INSERT && precedes) begin
                            r_insert <= 1'b1; r_pos <= r_idx; r_idx <= r_count;
                            r_state <= S_SRD;
                        end else if (r_op == splq_pkg::OP_REMOVE && match) begin
                            r_oent <= r_rd; r_insert <= 1'b0; r_state <= S_SRD;
                        end else r_idx <= r_idx + CW'(1);
                    end
                end
                S_TAKE: begin
                    // read of r_idx issued last cycle lands now
                    if (r_rvalid) begin
                        r_oent <= r_rd; r_insert <= 1'b0; r_rvalid <= 1'b0;
                        r_state <= S_SRD;
                    end else r_rvalid <= 1'b1;
                end
                // Shift step: read neighbor issued here
                S_SRD: begin
                    if (r_insert && r_idx == r_pos) begin
                        r_wr_en <= 1'b1; r_wr_addr <= r_pos[AW-1:0]; r_wr_data <= r_new;
                        r_count <= r_count + CW'(1); r_ocnt <= r_count + CW'(1);
                        r_state <= S_OUT;
                    end else if (!r_insert && r_idx + CW'(1) >= r_count) begin
                        r_count <= r_count - CW'(1); r_ocnt <= r_count - CW'(1);
                        r_state <= S_OUT;
                    end else r_state <= S_SWR;
                end
                S_SWR: begin
                    r_wr_en <= 1'b1; r_wr_addr <= r_idx[AW-1:0]; r_wr_data <= r_rd;
                    r_idx <= r_insert ? r_idx - CW'(1) : r_idx + CW'(1);
                    r_state <= S_SRD;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Checks
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(splq_pkg::Depth)) else $error("count over depth");
    a_no_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !req.ready) else $error("ready while busy");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |=> r_count == $past(r_count)) else $error("count moved");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !rsp.ready |=> r_ovalid) else $error("result dropped");
endmodule

### tb/splq_checker.sv
`timescale 1ns / 1ps
// Checker for the sorted priority list queue: watches the request, result and
// configuration channels, predicts each result and compares. Depends on splq_pkg, splq_if.
module splq_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    splq_req_if    req,
    splq_rsp_if    rsp,
    splq_cfg_if    cfg,
    output int     o_fail_count,
    output int     o_pending,
    output int     o_checked,
    output int     o_full_seen,
    output int     o_empty_seen
);
    typedef struct {
        logic [splq_pkg::TagBits-1:0]         tag;
        logic signed [splq_pkg::PrioBits-1:0] prio;
        splq_pkg::t_status                    status;
        logic [splq_pkg::CntBits-1:0]         count;
    } t_result;

    // Shadow copy of the list
    logic [splq_pkg::TagBits-1:0]         list_tags [splq_pkg::Depth];
    logic signed [splq_pkg::PrioBits-1:0] list_prios[splq_pkg::Depth];
    int                                   list_count;
    bit                                   smallest_first;
    t_result                              expected_results[$];

    // Open slot at pos and store the entry there
    function automatic void list_put(int pos, logic [splq_pkg::TagBits-1:0] tag,
                                     logic signed [splq_pkg::PrioBits-1:0] prio);
        for (int i = list_count; i > pos; i--) begin
            list_tags[i]  = list_tags[i-1];
            list_prios[i] = list_prios[i-1];
        end
        list_tags[pos]  = tag;
        list_prios[pos] = prio;
        list_count++;
    endfunction

    // Pull the entry at pos out and close the gap
    function automatic void list_take(int pos, ref t_result res);
        res.tag  = list_tags[pos];
        res.prio = list_prios[pos];
        for (int i = pos; i + 1 < list_count; i++) begin
            list_tags[i]  = list_tags[i+1];
            list_prios[i] = list_prios[i+1];
        end
        list_count--;
    endfunction

    function automatic t_result predict_queue_op(splq_pkg::t_op op,
                                                 logic [splq_pkg::TagBits-1:0] tag,
                                                 logic signed [splq_pkg::PrioBits-1:0] prio);
        t_result res;
        int      pos;
        res = '{tag: '0, prio: '0, status: splq_pkg::ST_DONE, count: '0};
        case (op)
            splq_pkg::OP_INSERT, splq_pkg::OP_PUSH_HEAD, splq_pkg::OP_PUSH_TAIL: begin
                if (list_count >= splq_pkg::Depth) begin
                    res.status = splq_pkg::ST_FULL;
                end else if (op == splq_pkg::OP_INSERT) begin
                    pos = list_count;
                    for (int i = 0; i < list_count; i++) begin
                        if (smallest_first ? (prio < list_prios[i])
                                           : (prio >= list_prios[i])) begin
                            pos = i;
                            break;
                        end
                    end
                    list_put(pos, tag, prio);
                end else begin
                    list_put(op == splq_pkg::OP_PUSH_HEAD ? 0 : list_count, tag, prio);
                end
            end
            splq_pkg::OP_POP_HEAD, splq_pkg::OP_POP_TAIL: begin
                if (list_count == 0) res.status = splq_pkg::ST_EMPTY;
                else list_take(op == splq_pkg::OP_POP_HEAD ? 0 : list_count - 1, res);
            end
            splq_pkg::OP_REMOVE: begin
                res.status = splq_pkg::ST_NOT_FOUND;
                for (int i = 0; i < list_count; i++) begin
                    if (list_tags[i] == tag) begin
                        list_take(i, res);
                        res.status = splq_pkg::ST_DONE;
                        break;
                    end
                end
            end
            default: ;
        endcase
        res.count = list_count[splq_pkg::CntBits-1:0];
        return res;
    endfunction

    // Compare results, then predict new requests, then take config writes
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            list_count     = 0;
            smallest_first = 1'b1;
            expected_results.delete();
            o_fail_count   = 0;
            o_checked      = 0;
            o_full_seen    = 0;
            o_empty_seen   = 0;
        end else begin
            if (rsp.valid && rsp.ready) begin
                o_checked++;
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("ERROR: result with nothing pending: tag %h prio %0d st %0d",
                                 rsp.out_tag, rsp.out_priority, rsp.status);
                end else begin
                    want = expected_results.pop_front();
                    if (rsp.out_tag !== want.tag || rsp.out_priority !== want.prio ||
                        rsp.status !== want.status || rsp.entry_count !== want.count) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"ERROR: result mismatch: expected tag %h prio %0d ",
                                      "st %0d cnt %0d, got tag %h prio %0d st %0d cnt %0d"},
                                     want.tag, want.prio, want.status, want.count,
                                     rsp.out_tag, rsp.out_priority, rsp.status,
                                     rsp.entry_count);
                    end
                end
            end
            if (req.valid && req.ready) begin
                want = predict_queue_op(splq_pkg::t_op'(req.op), req.tag, req.priority_req);
                if (want.status == splq_pkg::ST_FULL) o_full_seen++;
                if (want.status == splq_pkg::ST_EMPTY) o_empty_seen++;
                expected_results.push_back(want);
            end
            if (cfg.valid && cfg.ready) smallest_first = cfg.data;
        end
        o_pending = expected_results.size();
    end
endmodule

### tb/sorted_priority_list_queue_top_test.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the sorted priority list queue. Depends on splq_pkg,
// splq_if, the queue top level and splq_checker.
module sorted_priority_list_queue_top_test;
    localparam int CycleLimit = 2_000_000;
    localparam int SettleCycles = 200;

    logic i_clk;
    logic i_rst_n;
    int   cycle_count;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   fail_count, pending, checked, full_seen, empty_seen;

    splq_req_if req ();
    splq_rsp_if rsp ();
    splq_cfg_if cfg ();

    sorted_priority_list_queue_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .req     (req),
        .rsp     (rsp),
        .cfg     (cfg)
    );

    splq_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req          (req),
        .rsp          (rsp),
        .cfg          (cfg),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_full_seen  (full_seen),
        .o_empty_seen (empty_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result-side stalls
    initial rsp.ready = 1'b0;
    always @(posedge i_clk) rsp.ready <= ($urandom_range(99) >= rx_idle_pct);

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("TIMEOUT after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_request(splq_pkg::t_op op, logic [splq_pkg::TagBits-1:0] tag,
                                logic signed [splq_pkg::PrioBits-1:0] prio);
        while ($urandom_range(99) < tx_idle_pct) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
        end
        req.valid        <= 1'b1;
        req.op           <= op;
        req.tag          <= tag;
        req.priority_req <= prio;
        do @(posedge i_clk); while (!req.ready);
    endtask

    // Wait out every pending result, then let the block go quiet;
    // the count is sampled mid-cycle, after the checker has updated it
    task automatic drain();
        req.valid <= 1'b0;
        @(posedge i_clk);
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_order(bit smallest_first);
        cfg.valid <= 1'b1;
        cfg.data  <= smallest_first;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    task automatic send_random(int n);
        int grow_pct;
        int r;
        splq_pkg::t_op op;
        logic [splq_pkg::TagBits-1:0] tag;
        logic signed [splq_pkg::PrioBits-1:0] prio;
        for (int k = 0; k < n; k++) begin
            // Alternate filling and draining so the list hits full and empty
            grow_pct = ((k / 160) % 2 == 0) ? 82 : 22;
            r = $urandom_range(99);
            if (r < 3) op = splq_pkg::t_op'($urandom_range(7, 6));
            else if ($urandom_range(99) < grow_pct) begin
                r = $urandom_range(4);
                op = (r < 3) ? splq_pkg::OP_INSERT
                             : (r == 3 ? splq_pkg::OP_PUSH_HEAD : splq_pkg::OP_PUSH_TAIL);
            end else begin
                r = $urandom_range(3);
                op = (r == 0) ? splq_pkg::OP_POP_HEAD
                              : (r == 1 ? splq_pkg::OP_POP_TAIL : splq_pkg::OP_REMOVE);
            end
            tag = ($urandom_range(99) < 60) ? splq_pkg::TagBits'($urandom_range(15))
                                            : splq_pkg::TagBits'($urandom_range(65535));
            r = $urandom_range(99);
            if (r < 40) prio = splq_pkg::PrioBits'($signed($urandom_range(6)) - 3);
            else if (r < 45) prio = (r[0]) ? 16'sh7fff : 16'sh8000;
            else prio = splq_pkg::PrioBits'($urandom_range(65535));
            send_request(op, tag, prio);
        end
    endtask

    initial begin
        req.valid        = 1'b0;
        req.op           = splq_pkg::OP_INSERT;
        req.tag          = '0;
        req.priority_req = '0;
        cfg.valid        = 1'b0;
        cfg.data         = 1'b1;
        tx_idle_pct      = 29;
        rx_idle_pct      = 78;
        cycle_count      = 0;
        i_rst_n          = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty list cases, unused ops, extremes, equal priorities
        send_request(splq_pkg::OP_POP_HEAD, 16'h0001, 16'sd0);
        send_request(splq_pkg::OP_POP_TAIL, 16'h0002, 16'sd0);
        send_request(splq_pkg::OP_REMOVE, 16'h0003, 16'sd0);
        send_request(splq_pkg::t_op'(3'd6), 16'hffff, 16'sh7fff);
        send_request(splq_pkg::t_op'(3'd7), 16'h0000, 16'sh8000);
        send_request(splq_pkg::OP_INSERT, 16'h0000, 16'sh7fff);
        send_request(splq_pkg::OP_INSERT, 16'hffff, 16'sh8000);
        send_request(splq_pkg::OP_INSERT, 16'h0010, 16'sd5);
        send_request(splq_pkg::OP_INSERT, 16'h0011, 16'sd5);
        send_request(splq_pkg::OP_PUSH_HEAD, 16'h0012, 16'sd1);
        send_request(splq_pkg::OP_PUSH_TAIL, 16'h0013, -16'sd1);
        send_request(splq_pkg::OP_REMOVE, 16'h0011, 16'sd0);
        send_request(splq_pkg::OP_REMOVE, 16'h5555, 16'sd0);
        send_request(splq_pkg::OP_POP_HEAD, 16'h0000, 16'sd0);
        send_request(splq_pkg::OP_POP_TAIL, 16'h0000, 16'sd0);
        drain();
        write_order(1'b0);
        send_request(splq_pkg::OP_INSERT, 16'haaaa, 16'sd5);
        send_request(splq_pkg::OP_INSERT, 16'h5555, 16'sd5);
        send_request(splq_pkg::OP_INSERT, 16'h1234, 16'sh7fff);
        send_request(splq_pkg::OP_INSERT, 16'h4321, 16'sh8000);
        send_request(splq_pkg::OP_POP_HEAD, 16'h0000, 16'sd0);
        send_request(splq_pkg::OP_POP_HEAD, 16'h0000, 16'sd0);
        drain();

        // Random phases: three idling profiles, both orders each
        for (int ph = 0; ph < 6; ph++) begin
            case (ph / 2)
                0: begin tx_idle_pct = 29; rx_idle_pct = 78; end
                1: begin tx_idle_pct = 78; rx_idle_pct = 29; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            write_order(ph % 2 == 0);
            send_random(320);
            drain();
        end

        $display("Ran %0d results across both priority orders and three stall profiles;",
                 checked);
        $display("list-full errors seen %0d, list-empty errors seen %0d", full_seen, empty_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
